@@ rtl/pcrd_pkg.sv @@
package pcrd_pkg;

  localparam int unsigned CoordFracBits = 16;
  localparam int unsigned DirFracBits   = 14;
  localparam int unsigned ExtFracBits   = 12;
  localparam int unsigned NormBits      = 30;

  localparam int unsigned ScreenW = CoordFracBits + 1;
  localparam int unsigned CompW   = 16;
  localparam int unsigned VecW    = 3 * CompW;
  localparam int unsigned ExtW    = 16;
  localparam int unsigned NW      = CoordFracBits + 3;
  localparam int unsigned KW      = NW + ExtW + 1;
  localparam int unsigned ProdW   = KW + CompW;
  localparam int unsigned SumW    = 56;
  localparam int unsigned ShiftW  = 6;
  localparam int unsigned SqW     = 2 * NormBits;
  localparam int unsigned Sum2W   = SqW + 2;
  localparam int unsigned RootW   = Sum2W / 2;
  localparam int unsigned QW      = DirFracBits + 2;
  localparam int unsigned RemW    = NormBits + QW + 1;

  typedef enum logic [2:0] {
    RegForward    = 3'd0,
    RegRight      = 3'd1,
    RegUp         = 3'd2,
    RegHalfWidth  = 3'd3,
    RegHalfHeight = 3'd4
  } reg_idx_e;

endpackage

@@ rtl/pcrd_isqrt.sv @@
module pcrd_isqrt #(
  parameter int unsigned Width = 62,
  parameter int unsigned SideW = 94
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [Width-1:0]     value_i,
  input  logic [SideW-1:0]     side_i,
  output logic                 valid_o,
  output logic [Width/2-1:0]   root_o,
  output logic [SideW-1:0]     side_o
);

  localparam int unsigned NStage = Width / 2;

  logic [Width-1:0] rem_q  [NStage];
  logic [Width-1:0] res_q  [NStage];
  logic [SideW-1:0] side_q [NStage];
  logic [NStage-1:0] v_q;

  for (genvar i = 0; i < NStage; i++) begin : g_stage
    localparam logic [Width-1:0] BitV = Width'(1) << (Width - 2 - 2 * i);
    logic [Width-1:0] rem_in, res_in, rem_d, res_d, t;
    logic [SideW-1:0] side_in;
    logic             v_in;

    if (i == 0) begin : g_first
      assign rem_in  = value_i;
      assign res_in  = '0;
      assign side_in = side_i;
      assign v_in    = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[i-1];
      assign res_in  = res_q[i-1];
      assign side_in = side_q[i-1];
      assign v_in    = v_q[i-1];
    end

    always_comb begin
      t = res_in + BitV;
      if (rem_in >= t) begin
        rem_d = rem_in - t;
        res_d = (res_in >> 1) + BitV;
      end else begin
        rem_d = rem_in;
        res_d = res_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i] <= 1'b0;
      end else if (en_i) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= rem_d;
        res_q[i]  <= res_d;
        side_q[i] <= side_in;
      end
    end
  end

  assign valid_o = v_q[NStage-1];
  assign root_o  = res_q[NStage-1][Width/2-1:0];
  assign side_o  = side_q[NStage-1];

endmodule

@@ rtl/pinhole_camera_ray_direction.sv @@
// Pinhole camera primary ray generator. Each item carries a normalized screen
// position and yields one unit direction in signed Q1.14, with a flag for a
// zero-length direction. One item is accepted every clock cycle while the
// output is not stalled; it passes eight arithmetic stages, a 31-stage square
// root that settles one result bit per stage, a 16-stage divider that settles
// one quotient bit per stage for all three components, and the output register.
// A stalled output holds the whole pipeline. The user must ensure configuration
// is written only while no item is in flight; the block does not enforce it.
module pinhole_camera_ray_direction (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_addr_i,
  input  logic [47:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [16:0]         screen_x_i,
  input  logic [16:0]         screen_y_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [15:0]  dir_x_o,
  output logic signed [15:0]  dir_y_o,
  output logic signed [15:0]  dir_z_o,
  output logic                degenerate_o
);

  localparam int unsigned NW    = pcrd_pkg::NW;
  localparam int unsigned KW    = pcrd_pkg::KW;
  localparam int unsigned PW    = pcrd_pkg::ProdW;
  localparam int unsigned SW    = pcrd_pkg::SumW;
  localparam int unsigned AW    = pcrd_pkg::NormBits;
  localparam int unsigned S2W   = pcrd_pkg::Sum2W;
  localparam int unsigned RW    = pcrd_pkg::RootW;
  localparam int unsigned QW    = pcrd_pkg::QW;
  localparam int unsigned RemW  = pcrd_pkg::RemW;
  localparam int unsigned SideW = 3 * AW + 4;
  localparam int unsigned FShift = pcrd_pkg::CoordFracBits + pcrd_pkg::ExtFracBits;

  logic [47:0] fwd_q, right_q, up_q;
  logic [15:0] hw_q, hh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q   <= 48'd16384;
      right_q <= '0;
      up_q    <= '0;
      hw_q    <= 16'd4096;
      hh_q    <= 16'd4096;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        pcrd_pkg::RegForward:    fwd_q   <= cfg_data_i;
        pcrd_pkg::RegRight:      right_q <= cfg_data_i;
        pcrd_pkg::RegUp:         up_q    <= cfg_data_i;
        pcrd_pkg::RegHalfWidth:  hw_q    <= cfg_data_i[15:0];
        pcrd_pkg::RegHalfHeight: hh_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic out_v_q;
  assign en         = !out_v_q || out_ready_i;
  assign in_ready_o = en;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q;

  // Stage 1: map to [-1, 1].
  logic signed [NW-1:0] nx_q, ny_q;
  // Stage 2: scale by half extents.
  logic signed [KW-1:0] kx_q, ky_q;
  // Stage 3: basis products.
  logic signed [PW-1:0] pr_q [3];
  logic signed [PW-1:0] pu_q [3];
  // Stage 4: magnitudes.
  logic [SW-1:0] mag_q [3];
  logic [2:0]    neg4_q;
  // Stage 5: shift amount.
  logic [SW-1:0] mag5_q [3];
  logic [2:0]    neg5_q;
  logic [pcrd_pkg::ShiftW-1:0] k_q;
  logic          deg5_q;
  // Stage 6: normalized magnitudes.
  logic [AW-1:0] a6_q [3];
  logic [2:0]    neg6_q;
  logic          deg6_q;
  // Stage 7: squares.
  logic [pcrd_pkg::SqW-1:0] sq_q [3];
  logic [AW-1:0] a7_q [3];
  logic [2:0]    neg7_q;
  logic          deg7_q;
  // Stage 8: sum of squares.
  logic [S2W-1:0] sum2_q;
  logic [AW-1:0]  a8_q [3];
  logic [2:0]     neg8_q;
  logic           deg8_q;

  logic [SW-1:0] mag_d [3];
  logic [2:0]    neg_d;
  logic [SW-1:0] mag_or;
  logic [pcrd_pkg::ShiftW-1:0] k_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic signed [SW-1:0] s;
      logic signed [15:0]   f;
      f = fwd_q[16*i +: 16];
      s = (SW'(f) <<< FShift) + SW'(pr_q[i]) + SW'(pu_q[i]);
      neg_d[i] = s[SW-1];
      mag_d[i] = s[SW-1] ? (SW'(0) - SW'(s)) : SW'(s);
    end
  end

  always_comb begin
    int unsigned blen;
    blen = 0;
    mag_or = mag_q[0] | mag_q[1] | mag_q[2];
    for (int b = 0; b < SW; b++) begin
      if (mag_or[b]) blen = b + 1;
    end
    k_d = (blen > AW) ? pcrd_pkg::ShiftW'(blen - AW) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q} <= '0;
    end else if (en) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q <= $signed({1'b0, screen_x_i, 1'b0}) - NW'(1 << pcrd_pkg::CoordFracBits);
      ny_q <= NW'(1 << pcrd_pkg::CoordFracBits) - $signed({1'b0, screen_y_i, 1'b0});
      kx_q <= KW'(nx_q) * $signed({1'b0, hw_q});
      ky_q <= KW'(ny_q) * $signed({1'b0, hh_q});
      for (int i = 0; i < 3; i++) begin
        pr_q[i] <= PW'(kx_q) * PW'($signed(right_q[16*i +: 16]));
        pu_q[i] <= PW'(ky_q) * PW'($signed(up_q[16*i +: 16]));
        mag_q[i]  <= mag_d[i];
        mag5_q[i] <= mag_q[i];
        a6_q[i]   <= AW'(mag5_q[i] >> k_q);
        sq_q[i]   <= pcrd_pkg::SqW'(a6_q[i]) * pcrd_pkg::SqW'(a6_q[i]);
        a7_q[i]   <= a6_q[i];
        a8_q[i]   <= a7_q[i];
      end
      neg4_q <= neg_d;
      neg5_q <= neg4_q;
      k_q    <= k_d;
      deg5_q <= (mag_or == '0);
      neg6_q <= neg5_q;
      deg6_q <= deg5_q;
      neg7_q <= neg6_q;
      deg7_q <= deg6_q;
      sum2_q <= S2W'(sq_q[0]) + S2W'(sq_q[1]) + S2W'(sq_q[2]);
      neg8_q <= neg7_q;
      deg8_q <= deg7_q;
    end
  end

  logic             sq_v;
  logic [RW-1:0]    root;
  logic [SideW-1:0] side;

  pcrd_isqrt #(
    .Width (S2W),
    .SideW (SideW)
  ) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v8_q),
    .value_i (sum2_q),
    .side_i  ({deg8_q, neg8_q, a8_q[2], a8_q[1], a8_q[0]}),
    .valid_o (sq_v),
    .root_o  (root),
    .side_o  (side)
  );

  // Restoring division, one quotient bit per stage for each component.
  logic [RemW-1:0] rem_q [QW][3];
  logic [QW-1:0]   q_q   [QW][3];
  logic [RW-1:0]   r_q   [QW];
  logic [2:0]      negd_q [QW];
  logic            degd_q [QW];
  logic [QW-1:0]   vd_q;

  for (genvar s = 0; s < QW; s++) begin : g_div
    localparam int unsigned J = QW - 1 - s;
    logic [RemW-1:0] rem_in [3];
    logic [QW-1:0]   q_in   [3];
    logic [RW-1:0]   r_in;
    logic [2:0]      neg_in;
    logic            deg_in, v_in;
    logic [RemW-1:0] dv;

    if (s == 0) begin : g_first
      for (genvar c = 0; c < 3; c++) begin : g_c
        assign rem_in[c] = RemW'(side[AW*c +: AW]) << (QW - 1);
        assign q_in[c]   = '0;
      end
      assign r_in   = root;
      assign neg_in = side[3*AW +: 3];
      assign deg_in = side[SideW-1];
      assign v_in   = sq_v;
    end else begin : g_next
      for (genvar c = 0; c < 3; c++) begin : g_c
        assign rem_in[c] = rem_q[s-1][c];
        assign q_in[c]   = q_q[s-1][c];
      end
      assign r_in   = r_q[s-1];
      assign neg_in = negd_q[s-1];
      assign deg_in = degd_q[s-1];
      assign v_in   = vd_q[s-1];
    end

    assign dv = RemW'(r_in) << J;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vd_q[s] <= 1'b0;
      end else if (en) begin
        vd_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        for (int c = 0; c < 3; c++) begin
          if (rem_in[c] >= dv) begin
            rem_q[s][c] <= rem_in[c] - dv;
            q_q[s][c]   <= q_in[c] | (QW'(1) << J);
          end else begin
            rem_q[s][c] <= rem_in[c];
            q_q[s][c]   <= q_in[c];
          end
        end
        r_q[s]    <= r_in;
        negd_q[s] <= neg_in;
        degd_q[s] <= deg_in;
      end
    end
  end

  logic signed [15:0] dir_d [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [QW:0] qr;
      qr = (QW'(q_q[QW-1][c]) + (QW+1)'(1)) >> 1;
      if (degd_q[QW-1]) begin
        dir_d[c] = '0;
      end else if (negd_q[QW-1][c]) begin
        dir_d[c] = (qr > (QW+1)'(32768)) ? -16'sd32768 : 16'(-$signed({1'b0, qr}));
      end else begin
        dir_d[c] = (qr > (QW+1)'(32767)) ? 16'sd32767 : 16'(qr);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= vd_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dir_x_o      <= dir_d[0];
      dir_y_o      <= dir_d[1];
      dir_z_o      <= dir_d[2];
      degenerate_o <= degd_q[QW-1];
    end
  end

  assign out_valid_o = out_v_q;

endmodule
